>>> hdl/lmec_pkg.sv
// Package for the logistic map exponent color block.
// Widths, register indexes and fixed-point constants; no dependencies.
package lmec_pkg;

    localparam int MAX_PATTERN = 64;
    localparam int COUNT_BITS  = 16;
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int LEN_W       = 7;
    localparam int RATE_W      = 31;
    localparam int X_W         = 32;
    localparam int EXP_W       = 32;
    localparam int COLOR_W     = 8;
    localparam int DATA_W      = 64;
    localparam int REG_IDX_W   = 2;

    // shared multiplier
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 33;
    localparam int PROD_W  = 64;

    // log and accumulate
    localparam int FRAC_STEPS = 28;
    localparam int STEP_W     = 5;
    localparam int SUM_W      = 48;
    localparam int MAG_W      = SUM_W - 1;
    localparam logic [29:0] LN2_Q30 = 30'd744261118;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_BITS    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_ITERATION_COUNT = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_START_VALUE     = 2'd3;

    // reset values
    localparam logic [63:0]         RST_PATTERN_BITS = 64'd2;
    localparam logic [LEN_W-1:0]    RST_PATTERN_LEN  = 7'd2;
    localparam logic [COUNT_BITS-1:0] RST_ITER_COUNT = 16'd1024;
    localparam logic [X_W-1:0]      RST_START_VALUE  = 32'h8000_0000;

    localparam logic signed [EXP_W-1:0] EXP_MIN = 32'sh8000_0000;
    localparam logic signed [EXP_W-1:0] EXP_MAX = 32'sh7FFF_FFFF;

    typedef logic [COLOR_W-1:0] color_t;

endpackage

>>> hdl/lmec_if.sv
// Valid/ready channel interfaces for pixel items and color result items.
// Depends on lmec_pkg.
interface lmec_in_if
    import lmec_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [RATE_W-1:0] rate_a;
    logic [RATE_W-1:0] rate_b;

    modport source (output valid, output rate_a, output rate_b, input ready);
    modport sink   (input valid, input rate_a, input rate_b, output ready);
endinterface

interface lmec_out_if
    import lmec_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [EXP_W-1:0] exponent;
    color_t                  red;
    color_t                  green;
    color_t                  blue;
    logic                    log_saturated;

    modport source (output valid, output exponent, output red, output green,
                    output blue, output log_saturated, input ready);
    modport sink   (input valid, input exponent, input red, input green,
                    input blue, input log_saturated, output ready);
endinterface

>>> hdl/logistic_map_exponent_color.sv
// Top level: sequencer around one shared multiplier, divider and color ramp.
// Depends on lmec_pkg, lmec_if, lmec_mul, lmec_div, lmec_ramp.
//
//  channel | direction | payload                                   | handshake
//  pixel   | in        | rate_a, rate_b                            | valid/ready
//  color   | out       | exponent, red, green, blue, log_saturated | valid/ready
//  write   | in        | write_index, write_data                   | write_enable
//
// One item at a time. An item is accepted and the first map computed; each term
// then needs the check and derivative, normalization, 28 squarings, the ln
// scaling and the next map, all on the one multiplier. A final check, the mean
// in the divider, color and output follow. A zero count or a saturated log
// skips the divider.
// Reset clears the sequencer and loads the register reset values.
// A result waits in the output register until taken; pixel ready stays low.
module logistic_map_exponent_color
    import lmec_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    lmec_in_if.sink              pixel,
    lmec_out_if.source           color,
    input  logic                 write_enable,
    input  logic [REG_IDX_W-1:0] write_index,
    input  logic [DATA_W-1:0]    write_data
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MAP1  = 4'd1;
    localparam logic [3:0] S_MAP2  = 4'd2;
    localparam logic [3:0] S_MAP3  = 4'd3;
    localparam logic [3:0] S_CHECK = 4'd4;
    localparam logic [3:0] S_DER   = 4'd5;
    localparam logic [3:0] S_NORM  = 4'd6;
    localparam logic [3:0] S_SQ1   = 4'd7;
    localparam logic [3:0] S_SQ2   = 4'd8;
    localparam logic [3:0] S_LN1   = 4'd9;
    localparam logic [3:0] S_LN2   = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;
    localparam logic [3:0] S_DIV   = 4'd12;
    localparam logic [3:0] S_COLOR = 4'd13;
    localparam logic [3:0] S_OUT   = 4'd14;

    // configuration registers
    logic [63:0]           cfg_pat_reg;
    logic [LEN_W-1:0]      cfg_len_reg;
    logic [COUNT_BITS-1:0] cfg_cnt_reg;
    logic [X_W-1:0]        cfg_x0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_pat_reg <= RST_PATTERN_BITS;
            cfg_len_reg <= RST_PATTERN_LEN;
            cfg_cnt_reg <= RST_ITER_COUNT;
            cfg_x0_reg  <= RST_START_VALUE;
        end
        else if (write_enable)
        begin
            unique case (write_index)
                REG_PATTERN_BITS:    cfg_pat_reg <= write_data;
                REG_PATTERN_LENGTH:  cfg_len_reg <= write_data[LEN_W-1:0];
                REG_ITERATION_COUNT: cfg_cnt_reg <= write_data[COUNT_BITS-1:0];
                REG_START_VALUE:     cfg_x0_reg  <= write_data[X_W-1:0];
                default:             cfg_pat_reg <= cfg_pat_reg;
            endcase
        end
    end

    // datapath registers
    logic [3:0]              state_reg, state_next;
    logic [RATE_W-1:0]       ra_reg, rb_reg, r_reg;
    logic [63:0]             pat_reg;
    logic [LEN_W-1:0]        len_reg;
    logic [COUNT_BITS-1:0]   lim_reg, n_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic [X_W-1:0]          x_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic                    sat_reg;
    logic [63:0]             v_reg;
    logic [5:0]              k_reg;
    logic [31:0]             m_reg;
    logic [FRAC_STEPS-1:0]   frac_reg;
    logic [STEP_W-1:0]       step_reg;
    logic                    lneg_reg;
    logic signed [EXP_W-1:0] mean_reg;
    logic signed [EXP_W-1:0] exp_out_reg;
    color_t                  red_reg, green_reg, blue_reg;
    logic                    lsat_reg;

    logic                    accept;
    logic [LEN_W-1:0]        len_clamp;
    logic [MUL_A_W-1:0]      mul_a;
    logic [MUL_B_W-1:0]      mul_b;
    logic [PROD_W-1:0]       prod;
    logic [32:0]             ax;
    logic [7:0]              kd;
    logic signed [35:0]      lval;
    logic [35:0]             mag;
    logic [64:0]             rounded;
    logic [29:0]             term;
    logic [LEN_W-1:0]        idx_inc;
    logic [IDX_W-1:0]        nidx;
    logic                    div_start, div_done;
    logic [MAG_W-1:0]        smag, quo;
    logic                    sneg;
    color_t                  ramp_r, ramp_g, ramp_b;

    assign accept = pixel.valid && pixel.ready;
    assign pixel.ready = (state_reg == S_IDLE);

    always_comb
    begin
        if (cfg_len_reg == '0)
            len_clamp = LEN_W'(1);
        else if (cfg_len_reg > LEN_W'(MAX_PATTERN))
            len_clamp = LEN_W'(MAX_PATTERN);
        else
            len_clamp = cfg_len_reg;
    end

    // |1-2x| in Q1.32
    assign ax = x_reg[31] ? {1'b0, x_reg[30:0], 1'b0}
                          : (33'h1_0000_0000 - {x_reg, 1'b0});

    // signed Q.28 log2 and its magnitude
    assign kd      = {2'b00, k_reg} - 8'd60;
    assign lval    = $signed({kd, frac_reg});
    assign mag     = lval[35] ? 36'(-lval) : 36'(lval);
    assign rounded = {1'b0, prod} + 65'h2_0000_0000;
    assign term    = rounded[63:34];

    assign idx_inc = {1'b0, idx_reg} + 1'b1;
    assign nidx    = (idx_inc >= len_reg) ? '0 : idx_inc[IDX_W-1:0];

    assign sneg = sum_reg[SUM_W-1];
    assign smag = sneg ? MAG_W'(-sum_reg) : sum_reg[MAG_W-1:0];
    assign div_start = (state_reg == S_FIN) && !sat_reg && (lim_reg != '0);

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MAP1:
            begin
                mul_a = {2'b00, x_reg};
                mul_b = 33'h1_0000_0000 - {1'b0, x_reg};
            end
            S_MAP2:
            begin
                mul_a = {3'b000, r_reg};
                mul_b = {2'b00, prod[62:32]};
            end
            S_CHECK:
            begin
                mul_a = {3'b000, r_reg};
                mul_b = ax;
            end
            S_SQ1:
            begin
                mul_a = {2'b00, m_reg};
                mul_b = {1'b0, m_reg};
            end
            S_LN1:
            begin
                mul_a = mag[MUL_A_W-1:0];
                mul_b = {3'b000, LN2_Q30};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    lmec_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    lmec_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (smag),
        .divisor  (lim_reg),
        .done     (div_done),
        .quotient (quo)
    );

    lmec_ramp u_ramp (
        .e     (mean_reg),
        .red   (ramp_r),
        .green (ramp_g),
        .blue  (ramp_b)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept) state_next = S_MAP1;
            S_MAP1:  state_next = S_MAP2;
            S_MAP2:  state_next = S_MAP3;
            S_MAP3:  state_next = S_CHECK;
            S_CHECK: state_next = (n_reg == lim_reg) ? S_FIN : S_DER;
            S_DER:   state_next = (prod == '0) ? S_FIN : S_NORM;
            S_NORM:  if (v_reg[63]) state_next = S_SQ1;
            S_SQ1:   state_next = S_SQ2;
            S_SQ2:   state_next = (step_reg == STEP_W'(FRAC_STEPS - 1)) ? S_LN1 : S_SQ1;
            S_LN1:   state_next = S_LN2;
            S_LN2:   state_next = S_MAP1;
            S_FIN:   state_next = div_start ? S_DIV : S_COLOR;
            S_DIV:   if (div_done) state_next = S_COLOR;
            S_COLOR: state_next = S_OUT;
            S_OUT:   if (color.ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // datapath updates
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                ra_reg   <= pixel.rate_a;
                rb_reg   <= pixel.rate_b;
                r_reg    <= cfg_pat_reg[0] ? pixel.rate_b : pixel.rate_a;
                pat_reg  <= cfg_pat_reg;
                len_reg  <= len_clamp;
                lim_reg  <= cfg_cnt_reg;
                x_reg    <= cfg_x0_reg;
                idx_reg  <= '0;
                n_reg    <= '0;
                sum_reg  <= '0;
                sat_reg  <= 1'b0;
                mean_reg <= '0;
            end
            S_MAP3:
            begin
                x_reg <= (prod[63:60] != 4'd0) ? 32'hFFFF_FFFF : prod[59:28];
            end
            S_DER:
            begin
                v_reg <= prod;
                k_reg <= 6'd63;
                if (prod == '0)
                    sat_reg <= 1'b1;
            end
            S_NORM:
            begin
                if (v_reg[63])
                begin
                    m_reg    <= v_reg[63:32];
                    frac_reg <= '0;
                    step_reg <= '0;
                end
                else if (v_reg[63:56] == 8'd0)
                begin
                    v_reg <= {v_reg[55:0], 8'd0};
                    k_reg <= k_reg - 6'd8;
                end
                else
                begin
                    v_reg <= {v_reg[62:0], 1'b0};
                    k_reg <= k_reg - 6'd1;
                end
            end
            S_SQ2:
            begin
                // square >> 31; renormalize when it reaches two
                if (prod[63])
                begin
                    m_reg    <= prod[63:32];
                    frac_reg <= {frac_reg[FRAC_STEPS-2:0], 1'b1};
                end
                else
                begin
                    m_reg    <= prod[62:31];
                    frac_reg <= {frac_reg[FRAC_STEPS-2:0], 1'b0};
                end
                step_reg <= step_reg + 1'b1;
            end
            S_LN1:
            begin
                lneg_reg <= lval[35];
            end
            S_LN2:
            begin
                sum_reg <= lneg_reg ? (sum_reg - SUM_W'(term)) : (sum_reg + SUM_W'(term));
                n_reg   <= n_reg + 1'b1;
                idx_reg <= nidx;
                r_reg   <= pat_reg[nidx] ? rb_reg : ra_reg;
            end
            S_FIN:
            begin
                if (sat_reg)
                    mean_reg <= EXP_MIN;
            end
            S_DIV:
            begin
                // clamp the truncated quotient to 32 bits
                if (div_done)
                begin
                    if (!sneg && quo > MAG_W'(EXP_MAX))
                        mean_reg <= EXP_MAX;
                    else if (sneg && quo > MAG_W'(33'h1_0000_0000 >> 1))
                        mean_reg <= EXP_MIN;
                    else if (sneg)
                        mean_reg <= EXP_W'(-quo);
                    else
                        mean_reg <= quo[EXP_W-1:0];
                end
            end
            S_COLOR:
            begin
                exp_out_reg <= mean_reg;
                red_reg     <= ramp_r;
                green_reg   <= ramp_g;
                blue_reg    <= ramp_b;
                lsat_reg    <= sat_reg;
            end
            default:
            begin
                x_reg <= x_reg;
            end
        endcase
    end

    assign color.valid         = (state_reg == S_OUT);
    assign color.exponent      = exp_out_reg;
    assign color.red           = red_reg;
    assign color.green         = green_reg;
    assign color.blue          = blue_reg;
    assign color.log_saturated = lsat_reg;
endmodule

>>> hdl/lmec_mul.sv
// Shared unsigned multiplier with registered product.
// Depends on lmec_pkg.
module lmec_mul
    import lmec_pkg::*;
(
    input  logic               clk,
    input  logic [MUL_A_W-1:0] a,
    input  logic [MUL_B_W-1:0] b,
    output logic [PROD_W-1:0]  prod
);
    logic [MUL_A_W+MUL_B_W-1:0] full;
    logic [PROD_W-1:0]          prod_reg;

    assign full = a * b;

    // every operand pair used keeps its product within 64 bits
    always_ff @(posedge clk)
    begin
        prod_reg <= full[PROD_W-1:0];
    end

    assign prod = prod_reg;
endmodule

>>> hdl/lmec_div.sv
// Restoring divider, one quotient bit per cycle, for the mean.
// Depends on lmec_pkg.
module lmec_div
    import lmec_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [MAG_W-1:0]      dividend,
    input  logic [COUNT_BITS-1:0] divisor,
    output logic                  done,
    output logic [MAG_W-1:0]      quotient
);
    localparam int CNT_W = $clog2(MAG_W + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [COUNT_BITS:0]   rem_reg;
    logic [MAG_W-1:0]      quo_reg;
    logic [COUNT_BITS:0]   trial;
    logic                  fits;

    assign trial = {rem_reg[COUNT_BITS-1:0], quo_reg[MAG_W-1]};
    assign fits  = trial >= {1'b0, divisor};

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(MAG_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // shift and subtract
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (trial - {1'b0, divisor}) : trial;
            quo_reg <= {quo_reg[MAG_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

>>> hdl/lmec_ramp.sv
// Piecewise-linear color ramp of a Q8.24 exponent.
// Depends on lmec_pkg.
module lmec_ramp
    import lmec_pkg::*;
(
    input  logic signed [EXP_W-1:0] e,
    output color_t                  red,
    output color_t                  green,
    output color_t                  blue
);
    localparam logic signed [33:0] ONE   = 34'sd16777216;
    localparam logic signed [33:0] THREE = 34'sd50331648;

    function automatic logic [33:0] times255(input logic [33:0] t);
        times255 = {t[25:0], 8'b0} - t;
    endfunction

    logic signed [33:0] e34;
    logic [33:0]        t_lo, t_mid, t_hi, t_top;
    logic [33:0]        p_lo, p_mid, p_hi, p_top;

    assign e34   = {{2{e[EXP_W-1]}}, e};
    assign t_lo  = 34'(e34 + THREE);
    assign t_mid = 34'(e34 + ONE);
    assign t_hi  = 34'(e34);
    assign t_top = 34'(e34 - ONE);
    assign p_lo  = times255(t_lo);
    assign p_mid = times255(t_mid);
    assign p_hi  = times255(t_hi);
    assign p_top = times255(t_top);

    // pick the segment
    always_comb
    begin
        red   = '0;
        green = '0;
        blue  = '0;
        if (e34 > -THREE && e34 <= -ONE)
        begin
            red   = p_lo[32:25];
            green = p_lo[32:25];
        end
        else if (e34 > -ONE && e34 <= 34'sd0)
        begin
            red   = 8'hFF;
            green = 8'hFF;
            blue  = p_mid[31:24];
        end
        else if (e34 > 34'sd0 && e34 <= ONE)
        begin
            red   = 8'hFF - p_hi[31:24];
            green = 8'hFF - p_hi[31:24];
            blue  = 8'hFF;
        end
        else if (e34 > ONE && e34 <= THREE)
        begin
            blue  = 8'hFF - p_top[32:25];
        end
    end
endmodule

>>> hdl/lmec_chk.sv
// Port-level checker for the logistic map exponent color block, with bind.
// Depends on lmec_pkg and the top level's ports.
module lmec_chk
    import lmec_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic signed [EXP_W-1:0] exponent,
    input color_t                  red,
    input color_t                  green,
    input color_t                  blue,
    input logic                    log_saturated
);
    // a waiting result holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(exponent))
        else $error("exponent changed while stalled");

    // one item in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("ready while a result waits");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready && !out_valid)
        else $error("busy flag missing after accept");

    // saturated result is the minimum and black
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && log_saturated |->
            exponent == EXP_MIN && red == '0 && green == '0 && blue == '0)
        else $error("bad saturated result");
endmodule

bind logistic_map_exponent_color lmec_chk u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (pixel.valid),
    .in_ready      (pixel.ready),
    .out_valid     (color.valid),
    .out_ready     (color.ready),
    .exponent      (color.exponent),
    .red           (color.red),
    .green         (color.green),
    .blue          (color.blue),
    .log_saturated (color.log_saturated)
);
